// ----- rtl/timestamp_reorder_dedup_buffer_macros.svh -----
// ----------------------------------------------------------------------------
// timestamp reorder dedup buffer assertion macros
// shared concurrent assertion helpers, compiled out with ASSERT_OFF
// ----------------------------------------------------------------------------
`ifndef TIMESTAMP_REORDER_DEDUP_BUFFER_MACROS_SVH
`define TIMESTAMP_REORDER_DEDUP_BUFFER_MACROS_SVH

`ifndef ASSERT_OFF
`define TRDB_ASSERT(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");
`define TRDB_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define TRDB_ASSERT(lbl, clk, rst_n, cond)
`define TRDB_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/trdb_pkg.sv -----
// ----------------------------------------------------------------------------
// trdb_pkg
// types, constants and helpers of the timestamp reorder dedup buffer
// ----------------------------------------------------------------------------
package trdb_pkg;

  localparam int HOLD_DEPTH_DEF = 64;
  localparam int KEY_DEPTH_DEF  = 64;
  localparam int MAX_RESULTS    = 64;
  localparam int RES_CW         = 7;
  localparam logic [31:0] HALF_RANGE = 32'h8000_0000;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_FLUSH  = 1'b1;

  localparam logic CFG_DEDUP   = 1'b0;
  localparam logic CFG_REORDER = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [63:0] tick;
    logic [31:0] order;
    logic [63:0] newest;
    logic [31:0] addr;
    logic [23:0] crc;
    logic [7:0]  len;
    logic [63:0] fp;
    logic [15:0] handle;
  } item_t;

  typedef struct packed {
    logic [63:0] tick;
    logic [31:0] order;
    logic [15:0] handle;
    logic [31:0] addr;
    logic [23:0] crc;
    logic [7:0]  len;
    logic [63:0] fp;
  } rec_t;

  typedef struct packed {
    logic [31:0] addr;
    logic [23:0] crc;
    logic [7:0]  len;
    logic [63:0] fp;
    logic [63:0] tick;
  } key_t;

  function automatic logic earlier(rec_t a, rec_t b);
    logic [31:0] d;
    d = a.order - b.order;
    if (a.tick != b.tick) return a.tick < b.tick;
    return d[31];
  endfunction

  function automatic logic key_match(key_t k, rec_t r);
    return (k.addr == r.addr) && (k.crc == r.crc) && (k.len == r.len) && (k.fp == r.fp);
  endfunction

endpackage

// ----- rtl/trdb_ram.sv -----
// ----------------------------------------------------------------------------
// trdb_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module trdb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/trdb_fifo.sv -----
// ----------------------------------------------------------------------------
// trdb_fifo
// two entry word queue between the front and back parts
// ----------------------------------------------------------------------------
module trdb_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  output logic             pop_valid,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] slot_r [2];
  logic [1:0]       cnt_r, cnt_nxt;
  logic             wp_r, wp_nxt, rp_r, rp_nxt;

  assign full      = (cnt_r == 2'd2);
  assign pop_valid = (cnt_r != 2'd0);
  assign pop_data  = slot_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    if (push && !full) begin
      wp_nxt = ~wp_r;
      cnt_nxt = cnt_nxt + 2'd1;
    end
    if (pop && pop_valid) begin
      rp_nxt = ~rp_r;
      cnt_nxt = cnt_nxt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) slot_r[wp_r] <= push_data;
  end

endmodule

// ----- rtl/trdb_front.sv -----
// ----------------------------------------------------------------------------
// trdb_front
// accepts words, widens ticks, numbers arrivals and tracks the newest tick
// ----------------------------------------------------------------------------
module trdb_front import trdb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_command,
  input  logic [31:0] in_aligned_tick,
  input  logic [31:0] in_access_address,
  input  logic [23:0] in_packet_crc,
  input  logic [7:0]  in_pdu_length,
  input  logic [63:0] in_pdu_fingerprint,
  input  logic [15:0] in_packet_handle,
  input  logic        q_full,
  output logic        q_push,
  output item_t       q_item
);

  logic        first_r, first_nxt;
  logic [31:0] prev_r, prev_nxt;
  logic [31:0] wrap_r, wrap_nxt;
  logic [31:0] arr_r, arr_nxt;
  logic        nv_r, nv_nxt;
  logic [63:0] newest_r, newest_nxt;
  logic [31:0] drop;
  logic [63:0] tick;
  logic        ins;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;
  assign ins      = q_push && (in_command == CMD_INSERT);
  assign drop     = prev_r - in_aligned_tick;

  always_comb begin
    first_nxt  = first_r;
    prev_nxt   = prev_r;
    wrap_nxt   = wrap_r;
    arr_nxt    = arr_r;
    nv_nxt     = nv_r;
    newest_nxt = newest_r;
    tick       = {32'd0, in_aligned_tick};
    if (first_r) begin
      if (in_aligned_tick < prev_r && drop > HALF_RANGE) wrap_nxt = wrap_r + 32'd1;
      tick = {wrap_nxt, in_aligned_tick};
    end
    if (ins) begin
      first_nxt = 1'b1;
      arr_nxt   = arr_r + 32'd1;
      if (!first_r || in_aligned_tick > prev_r || drop > HALF_RANGE)
        prev_nxt = in_aligned_tick;
      if (!nv_r || tick > newest_r) begin
        nv_nxt     = 1'b1;
        newest_nxt = tick;
      end
    end else begin
      wrap_nxt = wrap_r;
    end
  end

  always_comb begin
    q_item        = '0;
    q_item.cmd    = in_command;
    q_item.tick   = tick;
    q_item.order  = arr_r;
    q_item.newest = newest_nxt;
    q_item.addr   = in_access_address;
    q_item.crc    = in_packet_crc;
    q_item.len    = in_pdu_length;
    q_item.fp     = in_pdu_fingerprint;
    q_item.handle = in_packet_handle;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r  <= 1'b0;
      prev_r   <= 32'd0;
      wrap_r   <= 32'd0;
      arr_r    <= 32'd0;
      nv_r     <= 1'b0;
      newest_r <= 64'd0;
    end else begin
      first_r  <= first_nxt;
      prev_r   <= prev_nxt;
      wrap_r   <= wrap_nxt;
      arr_r    <= arr_nxt;
      nv_r     <= nv_nxt;
      newest_r <= newest_nxt;
    end
  end

endmodule

// ----- rtl/trdb_back.sv -----
// ----------------------------------------------------------------------------
// trdb_back
// holds records, releases them in tick order and marks duplicate keys
// ----------------------------------------------------------------------------
module trdb_back import trdb_pkg::*; #(
  parameter int HOLD_DEPTH = HOLD_DEPTH_DEF,
  parameter int KEY_DEPTH  = KEY_DEPTH_DEF,
  parameter int HA = $clog2(HOLD_DEPTH),
  parameter int CW = $clog2(HOLD_DEPTH + 1),
  parameter int KA = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1,
  parameter int KC = $clog2(KEY_DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [31:0]   dedup_window,
  input  logic [31:0]   reorder_window,
  input  logic          q_valid,
  input  item_t         q_item,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [15:0]   out_released_handle,
  output logic [63:0]   out_extended_tick,
  output logic          out_duplicate,
  output logic          out_last_of_run,
  output logic [CW-1:0] held_cnt,
  output logic [KC-1:0] key_cnt
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_BSTART = 5'd1;
  localparam logic [4:0] S_LOOP  = 5'd2;
  localparam logic [4:0] S_SCAN  = 5'd3;
  localparam logic [4:0] S_DEC   = 5'd4;
  localparam logic [4:0] S_KSCAN = 5'd5;
  localparam logic [4:0] S_KDIFF = 5'd6;
  localparam logic [4:0] S_KDEC  = 5'd7;
  localparam logic [4:0] S_EMIT  = 5'd8;
  localparam logic [4:0] S_MOVE  = 5'd9;
  localparam logic [4:0] S_MOVEW = 5'd10;
  localparam logic [4:0] S_BDONE = 5'd11;
  localparam logic [4:0] S_PRD   = 5'd12;
  localparam logic [4:0] S_PWAIT = 5'd13;
  localparam logic [4:0] S_PCHK  = 5'd14;
  localparam logic [4:0] S_PCPYW = 5'd15;
  localparam logic [4:0] S_NEXT  = 5'd16;
  localparam logic [4:0] S_WRITE = 5'd17;
  localparam logic [4:0] S_END   = 5'd18;

  localparam logic [1:0] PH_FLUSH = 2'd0;
  localparam logic [1:0] PH_PRE   = 2'd1;
  localparam logic [1:0] PH_NORM  = 2'd2;
  localparam logic [1:0] PH_POST  = 2'd3;

  localparam logic [CW-1:0] HOLD_FULL = CW'(HOLD_DEPTH);
  localparam logic [KC-1:0] KEY_FULL  = KC'(KEY_DEPTH);
  localparam logic [RES_CW-1:0] RES_MAX = RES_CW'(MAX_RESULTS);

  logic [4:0]        state_r, state_nxt;
  logic [1:0]        phase_r, phase_nxt;
  logic              all_r, all_nxt;
  item_t             cur_r, cur_nxt;
  logic [63:0]       cutoff_r, cutoff_nxt;
  logic [CW-1:0]     hcnt_r, hcnt_nxt;
  logic [KC-1:0]     kcnt_r, kcnt_nxt;
  logic [RES_CW-1:0] n_r, n_nxt;
  logic              any_r, any_nxt;
  logic [63:0]       last_r, last_nxt;
  logic [CW-1:0]     scan_r, scan_nxt, ridx_r, ridx_nxt;
  logic              rpend_r, rpend_nxt;
  rec_t              best_r, best_nxt;
  logic [HA-1:0]     bidx_r, bidx_nxt;
  logic [KC-1:0]     kscan_r, kscan_nxt, kidx_r, kidx_nxt, pi_r, pi_nxt;
  logic              kpend_r, kpend_nxt, found_r, found_nxt;
  logic [KA-1:0]     fidx_r, fidx_nxt;
  logic [63:0]       ftick_r, ftick_nxt, dist_r, dist_nxt, pdiff_r, pdiff_nxt;
  logic              dup_r, dup_nxt;
  logic              pv_r, pv_nxt;
  logic [15:0]       ph_r, ph_nxt;
  logic [63:0]       pt_r, pt_nxt;
  logic              pd_r, pd_nxt;
  logic              ov_r, ov_nxt;
  logic [15:0]       oh_r, oh_nxt;
  logic [63:0]       ot_r, ot_nxt;
  logic              od_r, od_nxt, ol_r, ol_nxt;

  logic              h_we;
  logic [HA-1:0]     h_wa, h_ra;
  rec_t              h_wd, h_rd;
  logic              k_we;
  logic [KA-1:0]     k_wa, k_ra;
  key_t              k_wd, k_rd;
  logic              out_free;
  logic [63:0]       horizon;
  rec_t              new_rec;
  key_t              new_key;
  logic [CW-1:0]     hcnt_m1;
  logic [KC-1:0]     kcnt_m1;

  trdb_ram #(.WIDTH($bits(rec_t)), .DEPTH(HOLD_DEPTH), .AW(HA)) u_hold (
    .clk(clk), .we(h_we), .waddr(h_wa), .wdata(h_wd), .raddr(h_ra), .rdata(h_rd)
  );

  trdb_ram #(.WIDTH($bits(key_t)), .DEPTH(KEY_DEPTH), .AW(KA)) u_keys (
    .clk(clk), .we(k_we), .waddr(k_wa), .wdata(k_wd), .raddr(k_ra), .rdata(k_rd)
  );

  assign out_free            = !ov_r || out_ready;
  assign out_valid           = ov_r;
  assign out_released_handle = oh_r;
  assign out_extended_tick   = ot_r;
  assign out_duplicate       = od_r;
  assign out_last_of_run     = ol_r;
  assign held_cnt            = hcnt_r;
  assign key_cnt             = kcnt_r;
  assign q_pop               = (state_r == S_IDLE) && q_valid;
  assign horizon             = {32'd0, reorder_window} + {29'd0, dedup_window, 3'd0};
  assign hcnt_m1             = hcnt_r - CW'(1);
  assign kcnt_m1             = kcnt_r - KC'(1);

  always_comb begin
    new_rec        = '0;
    new_rec.tick   = cur_r.tick;
    new_rec.order  = cur_r.order;
    new_rec.handle = cur_r.handle;
    new_rec.addr   = cur_r.addr;
    new_rec.crc    = cur_r.crc;
    new_rec.len    = cur_r.len;
    new_rec.fp     = cur_r.fp;
    new_key        = '0;
    new_key.addr   = best_r.addr;
    new_key.crc    = best_r.crc;
    new_key.len    = best_r.len;
    new_key.fp     = best_r.fp;
    new_key.tick   = best_r.tick;
  end

  always_comb begin
    state_nxt = state_r;  phase_nxt = phase_r;  all_nxt = all_r;  cur_nxt = cur_r;
    cutoff_nxt = cutoff_r; hcnt_nxt = hcnt_r;   kcnt_nxt = kcnt_r; n_nxt = n_r;
    any_nxt = any_r;      last_nxt = last_r;    scan_nxt = scan_r; ridx_nxt = ridx_r;
    rpend_nxt = 1'b0;     best_nxt = best_r;    bidx_nxt = bidx_r; kscan_nxt = kscan_r;
    kidx_nxt = kidx_r;    pi_nxt = pi_r;        kpend_nxt = 1'b0;  found_nxt = found_r;
    fidx_nxt = fidx_r;    ftick_nxt = ftick_r;  dist_nxt = dist_r; pdiff_nxt = pdiff_r;
    dup_nxt = dup_r;      pv_nxt = pv_r;        ph_nxt = ph_r;     pt_nxt = pt_r;
    pd_nxt = pd_r;        oh_nxt = oh_r;        ot_nxt = ot_r;     od_nxt = od_r;
    ol_nxt = ol_r;
    ov_nxt = ov_r && !out_ready;
    h_we = 1'b0; h_wa = hcnt_r[HA-1:0]; h_wd = new_rec; h_ra = scan_r[HA-1:0];
    k_we = 1'b0; k_wa = fidx_r;         k_wd = new_key; k_ra = kscan_r[KA-1:0];
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          cur_nxt = q_item;
          n_nxt   = '0;
          all_nxt = 1'b1;
          if (q_item.cmd == CMD_FLUSH) begin
            phase_nxt = PH_FLUSH;
            state_nxt = S_BSTART;
          end else if (hcnt_r >= HOLD_FULL) begin
            phase_nxt = PH_PRE;
            state_nxt = S_BSTART;
          end else begin
            phase_nxt = PH_PRE;
            state_nxt = S_WRITE;
          end
        end
      end
      S_WRITE: begin
        h_we      = 1'b1;
        hcnt_nxt  = hcnt_r + CW'(1);
        phase_nxt = PH_NORM;
        all_nxt   = 1'b0;
        state_nxt = S_BSTART;
      end
      S_BSTART: begin
        any_nxt    = 1'b0;
        cutoff_nxt = cur_r.newest - {32'd0, reorder_window};
        if (hcnt_r == '0) state_nxt = S_NEXT;
        else if (!all_r && cur_r.newest < {32'd0, reorder_window}) state_nxt = S_NEXT;
        else state_nxt = S_LOOP;
      end
      S_LOOP: begin
        scan_nxt = '0;
        if (hcnt_r != '0 && n_r < RES_MAX) state_nxt = S_SCAN;
        else state_nxt = S_BDONE;
      end
      S_SCAN: begin
        if (scan_r < hcnt_r) begin
          scan_nxt  = scan_r + CW'(1);
          rpend_nxt = 1'b1;
          ridx_nxt  = scan_r;
        end
        if (rpend_r && (ridx_r == '0 || earlier(h_rd, best_r))) begin
          best_nxt = h_rd;
          bidx_nxt = ridx_r[HA-1:0];
        end
        if (scan_r == hcnt_r && !rpend_r) state_nxt = S_DEC;
      end
      S_DEC: begin
        kscan_nxt = '0;
        found_nxt = 1'b0;
        if (!all_r && best_r.tick > cutoff_r) state_nxt = S_BDONE;
        else state_nxt = S_KSCAN;
      end
      S_KSCAN: begin
        if (!found_r && kscan_r < kcnt_r) begin
          kscan_nxt = kscan_r + KC'(1);
          kpend_nxt = 1'b1;
          kidx_nxt  = kscan_r;
        end
        if (kpend_r && !found_r && key_match(k_rd, best_r)) begin
          found_nxt = 1'b1;
          fidx_nxt  = kidx_r[KA-1:0];
          ftick_nxt = k_rd.tick;
        end
        if (found_r || (kscan_r == kcnt_r && !kpend_r)) state_nxt = S_KDIFF;
      end
      S_KDIFF: begin
        dist_nxt  = (best_r.tick >= ftick_r) ? best_r.tick - ftick_r : ftick_r - best_r.tick;
        state_nxt = S_KDEC;
      end
      S_KDEC: begin
        dup_nxt = 1'b0;
        if (found_r) begin
          if (dist_r <= {32'd0, dedup_window}) dup_nxt = 1'b1;
          else k_we = 1'b1;
        end else if (kcnt_r < KEY_FULL) begin
          k_we     = 1'b1;
          k_wa     = kcnt_r[KA-1:0];
          kcnt_nxt = kcnt_r + KC'(1);
        end
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!pv_r || out_free) begin
          if (pv_r) begin
            ov_nxt = 1'b1; oh_nxt = ph_r; ot_nxt = pt_r; od_nxt = pd_r; ol_nxt = 1'b0;
          end
          pv_nxt    = 1'b1;
          ph_nxt    = best_r.handle;
          pt_nxt    = best_r.tick;
          pd_nxt    = dup_r;
          n_nxt     = n_r + RES_CW'(1);
          any_nxt   = 1'b1;
          last_nxt  = best_r.tick;
          state_nxt = S_MOVE;
        end
      end
      S_MOVE: begin
        h_ra      = hcnt_m1[HA-1:0];
        state_nxt = S_MOVEW;
      end
      S_MOVEW: begin
        h_we      = 1'b1;
        h_wa      = bidx_r;
        h_wd      = h_rd;
        hcnt_nxt  = hcnt_m1;
        state_nxt = S_LOOP;
      end
      S_BDONE: begin
        pi_nxt    = '0;
        state_nxt = any_r ? S_PRD : S_NEXT;
      end
      S_PRD: begin
        k_ra = pi_r[KA-1:0];
        if (pi_r < kcnt_r) state_nxt = S_PWAIT;
        else state_nxt = S_NEXT;
      end
      S_PWAIT: begin
        pdiff_nxt = last_r - k_rd.tick;
        state_nxt = S_PCHK;
      end
      S_PCHK: begin
        if (!pdiff_r[63] && pdiff_r > horizon) begin
          k_ra      = kcnt_m1[KA-1:0];
          state_nxt = S_PCPYW;
        end else begin
          pi_nxt    = pi_r + KC'(1);
          state_nxt = S_PRD;
        end
      end
      S_PCPYW: begin
        k_we      = 1'b1;
        k_wa      = pi_r[KA-1:0];
        k_wd      = k_rd;
        kcnt_nxt  = kcnt_m1;
        state_nxt = S_PRD;
      end
      S_NEXT: begin
        case (phase_r)
          PH_PRE: begin
            // still full after the release limit: the word is dropped
            if (hcnt_r >= HOLD_FULL) state_nxt = S_END;
            else state_nxt = S_WRITE;
          end
          PH_NORM: begin
            if (hcnt_r >= HOLD_FULL) begin
              phase_nxt = PH_POST;
              all_nxt   = 1'b1;
              state_nxt = S_BSTART;
            end else begin
              state_nxt = S_END;
            end
          end
          default: state_nxt = S_END;
        endcase
      end
      S_END: begin
        if (!pv_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          ov_nxt = 1'b1; oh_nxt = ph_r; ot_nxt = pt_r; od_nxt = pd_r; ol_nxt = 1'b1;
          pv_nxt    = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      hcnt_r  <= '0;
      kcnt_r  <= '0;
      rpend_r <= 1'b0;
      kpend_r <= 1'b0;
      pv_r    <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      hcnt_r  <= hcnt_nxt;
      kcnt_r  <= kcnt_nxt;
      rpend_r <= rpend_nxt;
      kpend_r <= kpend_nxt;
      pv_r    <= pv_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    phase_r <= phase_nxt;  all_r <= all_nxt;    cur_r <= cur_nxt;    cutoff_r <= cutoff_nxt;
    n_r <= n_nxt;          any_r <= any_nxt;    last_r <= last_nxt;  scan_r <= scan_nxt;
    ridx_r <= ridx_nxt;    best_r <= best_nxt;  bidx_r <= bidx_nxt;  kscan_r <= kscan_nxt;
    kidx_r <= kidx_nxt;    pi_r <= pi_nxt;      found_r <= found_nxt; fidx_r <= fidx_nxt;
    ftick_r <= ftick_nxt;  dist_r <= dist_nxt;  pdiff_r <= pdiff_nxt; dup_r <= dup_nxt;
    ph_r <= ph_nxt;        pt_r <= pt_nxt;      pd_r <= pd_nxt;      oh_r <= oh_nxt;
    ot_r <= ot_nxt;        od_r <= od_nxt;      ol_r <= ol_nxt;
  end

endmodule

// ----- rtl/timestamp_reorder_dedup_buffer.sv -----
// ----------------------------------------------------------------------------
// timestamp_reorder_dedup_buffer
// min tick reorder buffer with duplicate key marking
// ----------------------------------------------------------------------------
// the back part takes a word from the queue only when idle, so each word is
//   finished before the next; each released word takes a min search of the
//   hold ram and a key scan, and a prune pass reads each key and moves the last key over each drop
// throughput is set by the linear min search over the hold ram read port
// and the scan of the key ram, one entry per cycle each
// synchronous active low reset clears the held, key and arrival counts; rams need no clearing pass
`include "timestamp_reorder_dedup_buffer_macros.svh"

module timestamp_reorder_dedup_buffer import trdb_pkg::*; #(
  parameter int HOLD_DEPTH = HOLD_DEPTH_DEF,
  parameter int KEY_DEPTH  = KEY_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_command,
  input  logic [31:0] in_aligned_tick,
  input  logic [31:0] in_access_address,
  input  logic [23:0] in_packet_crc,
  input  logic [7:0]  in_pdu_length,
  input  logic [63:0] in_pdu_fingerprint,
  input  logic [15:0] in_packet_handle,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_released_handle,
  output logic [63:0] out_extended_tick,
  output logic        out_duplicate,
  output logic        out_last_of_run
);

  localparam int CW = $clog2(HOLD_DEPTH + 1);
  localparam int KC = $clog2(KEY_DEPTH + 1);

  logic [31:0]   dedup_r, reorder_r;
  logic          q_full, q_push, q_valid, q_pop;
  item_t         q_in, q_out;
  logic [CW-1:0] held_cnt;
  logic [KC-1:0] key_cnt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dedup_r   <= 32'd0;
      reorder_r <= 32'd0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_DEDUP) dedup_r <= cfg_data;
      if (cfg_index == CFG_REORDER) reorder_r <= cfg_data;
    end
  end

  trdb_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_command(in_command), .in_aligned_tick(in_aligned_tick),
    .in_access_address(in_access_address), .in_packet_crc(in_packet_crc),
    .in_pdu_length(in_pdu_length), .in_pdu_fingerprint(in_pdu_fingerprint),
    .in_packet_handle(in_packet_handle), .q_full(q_full), .q_push(q_push), .q_item(q_in)
  );

  trdb_fifo #(.WIDTH($bits(item_t))) u_fifo (
    .clk(clk), .rst_n(rst_n), .push(q_push), .push_data(q_in), .full(q_full),
    .pop_valid(q_valid), .pop(q_pop), .pop_data(q_out)
  );

  trdb_back #(.HOLD_DEPTH(HOLD_DEPTH), .KEY_DEPTH(KEY_DEPTH)) u_back (
    .clk(clk), .rst_n(rst_n), .dedup_window(dedup_r), .reorder_window(reorder_r),
    .q_valid(q_valid), .q_item(q_out), .q_pop(q_pop),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_released_handle(out_released_handle), .out_extended_tick(out_extended_tick),
    .out_duplicate(out_duplicate), .out_last_of_run(out_last_of_run),
    .held_cnt(held_cnt), .key_cnt(key_cnt)
  );

  `TRDB_ASSERT(a_held_bound, clk, rst_n, held_cnt <= CW'(HOLD_DEPTH))
  `TRDB_ASSERT(a_key_bound, clk, rst_n, key_cnt <= KC'(KEY_DEPTH))
  `TRDB_ASSERT_IMP(a_held_step, clk, rst_n, 1'b1, (held_cnt == $past(held_cnt)) || (held_cnt == $past(held_cnt) + CW'(1)) || (held_cnt + CW'(1) == $past(held_cnt)))

endmodule
